@@ rtl/lavm_pkg.sv @@
// lavm_pkg: widths, constants and rounding helpers for the look-at view matrix block
// no dependencies; imported by lavm_if.sv, lavm_norm.sv and look_at_view_matrix.sv
package lavm_pkg;

    localparam int COORD_W   = 32;   // q16.16 coordinate
    localparam int ONE_SHIFT = 16;   // fraction bits
    localparam int UNIT_W    = 18;   // normalized component, -1.0 .. +1.0
    localparam int UP_W      = 20;   // true up component after rounding
    localparam int DIFF_W    = 33;   // target - eye
    localparam int CROSS_W   = 51;   // unscaled f x up
    localparam int NORM_TOP  = 29;   // top bit of the largest scaled magnitude
    localparam int NORM_W    = NORM_TOP + 1;
    localparam int LEN_W     = 31;   // vector length after scaling
    localparam int QUO_W     = 17;   // quotient bits of one normalized magnitude

    localparam logic signed [COORD_W-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic [1:0] LAST_COL = 2'd3;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [UNIT_W-1:0]  unit_t;
    typedef logic signed [UP_W-1:0]    upv_t;

    // q32.32 value to its magnitude, rounded half away from zero to q32.16
    function automatic logic [47:0] rnd_mag(input logic signed [63:0] v);
        logic [63:0] a;
        begin
            a = v[63] ? 64'(-v) : 64'(v);
            return 48'((a + 64'h8000) >> ONE_SHIFT);
        end
    endfunction

    // sign and magnitude to a saturated q16.16 value
    function automatic logic signed [31:0] sat_sm(input logic neg, input logic [47:0] m);
        begin
            if (!neg)
                return (m > 48'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(32'(m));
            else
                return (m > 48'h8000_0000) ? 32'sh8000_0000 : -signed'(32'(m));
        end
    endfunction

endpackage

@@ rtl/lavm_if.sv @@
// lavm_if: request channel interfaces (valid/ready plus payload) of the look-at block
// depends on lavm_pkg
interface lavm_item_if;
    import lavm_pkg::*;
    logic   valid;
    logic   ready;
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
    coord_t up_x;
    coord_t up_y;
    coord_t up_z;
    modport source (output valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                    up_x, up_y, up_z, input ready);
    modport sink (input valid, eye_x, eye_y, eye_z, target_x, target_y, target_z,
                  up_x, up_y, up_z, output ready);
endinterface

interface lavm_col_if;
    import lavm_pkg::*;
    logic       valid;
    logic       ready;
    logic [1:0] column_index;
    coord_t     row0_value;
    coord_t     row1_value;
    coord_t     row2_value;
    coord_t     row3_value;
    logic       degenerate;
    logic       last_column;
    modport source (output valid, column_index, row0_value, row1_value, row2_value,
                    row3_value, degenerate, last_column, input ready);
    modport sink (input valid, column_index, row0_value, row1_value, row2_value,
                  row3_value, degenerate, last_column, output ready);
endinterface

@@ rtl/lavm_norm.sv @@
// lavm_norm: pipelined 3-vector normalizer (scale, square sum, sqrt, divide)
// depends on lavm_pkg
module lavm_norm #(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic signed [IN_W-1:0] v [3],
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_valid,
    output lavm_pkg::unit_t       unit_v [3],
    output logic                  zero,
    output logic [SIDE_W-1:0]     out_side
);
    import lavm_pkg::*;

    localparam int TOP_W  = $clog2(IN_W);
    localparam int SQ_W   = 2 * NORM_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int SQRT_N = LEN_W;
    localparam int DIV_N  = QUO_W;
    localparam int NUM_W  = NORM_W + ONE_SHIFT + 1;
    localparam int REM_W  = LEN_W + 1;
    localparam int TAG_W  = SIDE_W + 4;
    localparam int LAT    = 6 + SQRT_N + 1 + DIV_N + 1;

    logic             vld_reg [LAT];
    logic [TAG_W-1:0] tag_reg [LAT];

    logic [IN_W-1:0]   mag1_reg [3];
    logic [IN_W-1:0]   mag2_reg [3];
    logic [IN_W-1:0]   max2_reg;
    logic [IN_W-1:0]   mag3_reg [3];
    logic [TOP_W-1:0]  top3_reg;
    logic [NORM_W-1:0] nrm4_reg [3];
    logic [NORM_W-1:0] nrm5_reg [3];
    logic [SQ_W-1:0]   sq5_reg  [3];

    logic [SUM_W-1:0]  rad_reg [0:SQRT_N];
    logic [SUM_W-1:0]  res_reg [0:SQRT_N];
    logic [NORM_W-1:0] nrm_reg [0:SQRT_N][3];

    logic [LEN_W-1:0]  len_reg [0:DIV_N];
    logic [REM_W-1:0]  rem_reg [0:DIV_N][3];
    logic [DIV_N-1:0]  nlo_reg [0:DIV_N][3];
    logic [DIV_N-1:0]  quo_reg [0:DIV_N][3];

    unit_t             unit_reg [3];

    logic              in_zero;
    logic [TOP_W-1:0]  top_next;
    logic [NORM_W-1:0] nrm_next [3];
    logic [NUM_W-1:0]  num_next [3];
    logic [LEN_W-1:0]  len_next;

    assign in_zero = (v[0] == '0) && (v[1] == '0) && (v[2] == '0);

    // valid and tag line: zero flag, signs and side data ride along
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tag_reg[0] <= {in_zero, v[2][IN_W-1], v[1][IN_W-1], v[0][IN_W-1], in_side};
            for (int k = 1; k < LAT; k++)
                tag_reg[k] <= tag_reg[k-1];
        end
    end

    // leading one of the largest magnitude
    always_comb
    begin
        top_next = '0;
        for (int b = 0; b < IN_W; b++)
            if (max2_reg[b])
                top_next = TOP_W'(b);
    end

    // scale so the largest magnitude has its top bit at NORM_TOP
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (int'(top3_reg) >= NORM_TOP)
                nrm_next[i] = NORM_W'(mag3_reg[i] >> (int'(top3_reg) - NORM_TOP));
            else
                nrm_next[i] = NORM_W'({{NORM_W{1'b0}}, mag3_reg[i]}
                                       << (NORM_TOP - int'(top3_reg)));
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag1_reg[i] <= v[i][IN_W-1] ? IN_W'(-v[i]) : IN_W'(v[i]);
                mag2_reg[i] <= mag1_reg[i];
                mag3_reg[i] <= mag2_reg[i];
                nrm4_reg[i] <= nrm_next[i];
                nrm5_reg[i] <= nrm4_reg[i];
                sq5_reg[i]  <= nrm4_reg[i] * nrm4_reg[i];
                nrm_reg[0][i] <= nrm5_reg[i];
            end
            max2_reg <= (mag1_reg[0] > mag1_reg[1])
                        ? ((mag1_reg[0] > mag1_reg[2]) ? mag1_reg[0] : mag1_reg[2])
                        : ((mag1_reg[1] > mag1_reg[2]) ? mag1_reg[1] : mag1_reg[2]);
            top3_reg <= top_next;
            rad_reg[0] <= SUM_W'(sq5_reg[0]) + SUM_W'(sq5_reg[1]) + SUM_W'(sq5_reg[2]);
            res_reg[0] <= '0;
        end
    end

    // integer square root, one result bit per stage
    for (genvar k = 1; k <= SQRT_N; k++)
    begin : g_sqrt
        logic [SUM_W-1:0] bitv;
        logic [SUM_W-1:0] trial;
        assign bitv  = SUM_W'(1) << (2 * (SQRT_N - k));
        assign trial = res_reg[k-1] + bitv;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rad_reg[k-1] >= trial)
                begin
                    rad_reg[k] <= rad_reg[k-1] - trial;
                    res_reg[k] <= (res_reg[k-1] >> 1) + bitv;
                end
                else
                begin
                    rad_reg[k] <= rad_reg[k-1];
                    res_reg[k] <= res_reg[k-1] >> 1;
                end
                nrm_reg[k] <= nrm_reg[k-1];
            end
        end
    end

    // divider setup: numerator m * one + len / 2
    assign len_next = res_reg[SQRT_N][LEN_W-1:0];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            num_next[i] = NUM_W'({nrm_reg[SQRT_N][i], {ONE_SHIFT{1'b0}}})
                          + NUM_W'(len_next >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            len_reg[0] <= len_next;
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[0][i] <= REM_W'(num_next[i][NUM_W-1:DIV_N]);
                nlo_reg[0][i] <= num_next[i][DIV_N-1:0];
                quo_reg[0][i] <= '0;
            end
        end
    end

    // restoring divide, one quotient bit per stage, three lanes
    for (genvar j = 1; j <= DIV_N; j++)
    begin : g_div
        for (genvar i = 0; i < 3; i++)
        begin : g_lane
            logic [REM_W-1:0] shl;
            logic             fit;
            assign shl = {rem_reg[j-1][i][REM_W-2:0], nlo_reg[j-1][i][DIV_N-j]};
            assign fit = shl >= REM_W'(len_reg[j-1]);
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[j][i] <= fit ? shl - REM_W'(len_reg[j-1]) : shl;
                    quo_reg[j][i] <= {quo_reg[j-1][i][DIV_N-2:0], fit};
                    nlo_reg[j][i] <= nlo_reg[j-1][i];
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                len_reg[j] <= len_reg[j-1];
        end
    end

    // sign applied, zero vector forced to zero
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (tag_reg[LAT-2][SIDE_W+3])
                    unit_reg[i] <= '0;
                else if (tag_reg[LAT-2][SIDE_W+i])
                    unit_reg[i] <= -signed'(UNIT_W'(quo_reg[DIV_N][i]));
                else
                    unit_reg[i] <= signed'(UNIT_W'(quo_reg[DIV_N][i]));
            end
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign zero      = tag_reg[LAT-1][SIDE_W+3];
    assign out_side  = tag_reg[LAT-1][SIDE_W-1:0];
    assign unit_v    = unit_reg;

endmodule

@@ rtl/look_at_view_matrix.sv @@
// look_at_view_matrix: right-handed q16.16 look-at view matrix, four column requests per input
// depends on lavm_pkg, lavm_if (lavm_item_if, lavm_col_if) and lavm_norm
//
//  channel  dir  handshake     payload
//  items    in   valid/ready   eye_x..z, target_x..z, up_x..z (signed q16.16)
//  columns  out  valid/ready   column_index, row0..row3_value, degenerate, last_column
//
// one input request gives four column requests, read out of the single column output
// register, which takes a new matrix only once its last column is taken; inputs may enter
// on consecutive cycles unless the pipeline freezes. most of the pipeline lies in the two
// normalizers (31 square-root and 17 divide stages each). reset clears the valid bits and
// the output register's full flag and column counter only. when a finished matrix sits in
// the last stage while the output register still holds an earlier one, the whole pipeline
// freezes and nothing is dropped.
module look_at_view_matrix (
    input  logic        clk,
    input  logic        rst_n,
    lavm_item_if.sink   items,
    lavm_col_if.source  columns
);
    import lavm_pkg::*;

    localparam int SIDE1_W = 6 * COORD_W;
    localparam int SIDE2_W = 3 * COORD_W + 3 * UNIT_W + 1;
    localparam int PFU_W   = UNIT_W + COORD_W;
    localparam int PSF_W   = 2 * UNIT_W;
    localparam int PUE_W   = UP_W + COORD_W;
    localparam int DOT_W   = PFU_W + 2;
    localparam int DOTU_W  = PUE_W + 2;
    localparam int UR_W    = PSF_W + 1;

    logic adv;          // global pipeline advance
    logic ser_take;     // output register can load a new matrix

    // stage 1: input capture, forward difference
    logic               v1_reg;
    logic signed [DIFF_W-1:0] d1_reg [3];
    coord_t             eye1_reg [3];
    coord_t             up1_reg  [3];

    // first normalizer (forward)
    logic               n1_valid;
    unit_t              f_n1 [3];
    logic               zf_n1;
    logic [SIDE1_W-1:0] side1_in, side1_out;
    coord_t             eye_n1 [3];
    coord_t             up_n1  [3];

    // stages 2-3: f x up
    logic               v2_reg, v3_reg;
    logic signed [PFU_W-1:0]   pa2_reg [3];
    logic signed [PFU_W-1:0]   pb2_reg [3];
    logic signed [CROSS_W-1:0] sr3_reg [3];
    coord_t             eye2_reg [3], eye3_reg [3];
    unit_t              f2_reg [3], f3_reg [3];
    logic               zf2_reg, zf3_reg;

    // second normalizer (right)
    logic               n2_valid;
    unit_t              s_n2 [3];
    logic               zs_n2;
    logic [SIDE2_W-1:0] side2_in, side2_out;
    coord_t             eye_n2 [3];
    unit_t              f_n2 [3];

    // stages 4-9: true up and translation
    logic               v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg;
    logic signed [PSF_W-1:0]  psa4_reg [3];
    logic signed [PSF_W-1:0]  psb4_reg [3];
    logic signed [PFU_W-1:0]  pse4_reg [3];
    logic signed [PFU_W-1:0]  pfe4_reg [3];
    logic signed [UR_W-1:0]   ur5_reg  [3];
    logic signed [DOT_W-1:0]  ds5_reg, df5_reg;
    upv_t               u6_reg [3], u7_reg [3], u8_reg [3], u9_reg [3];
    logic signed [PUE_W-1:0]  pue7_reg [3];
    logic signed [DOTU_W-1:0] du8_reg;
    unit_t              s4_reg [3], s5_reg [3], s6_reg [3], s7_reg [3], s8_reg [3], s9_reg [3];
    unit_t              f4_reg [3], f5_reg [3], f6_reg [3], f7_reg [3], f8_reg [3], f9_reg [3];
    coord_t             eye4_reg [3], eye5_reg [3], eye6_reg [3];
    coord_t             t0_6_reg, t0_7_reg, t0_8_reg, t0_9_reg;   // column 3, row 0
    coord_t             t2_6_reg, t2_7_reg, t2_8_reg, t2_9_reg;   // column 3, row 2
    coord_t             t1_9_reg;                                 // column 3, row 1
    logic               dg4_reg, dg5_reg, dg6_reg, dg7_reg, dg8_reg, dg9_reg;

    // output register: one whole matrix, read out a column at a time
    logic               full_reg;
    logic [1:0]         col_reg;
    unit_t              so_reg [3];
    upv_t               uo_reg [3];
    unit_t              fo_reg [3];
    coord_t             to_reg [3];
    logic               dgo_reg;
    logic               col_last;

    assign col_last = (col_reg == LAST_COL);
    assign ser_take = !full_reg || (columns.ready && col_last);
    assign adv      = !v9_reg || ser_take;
    assign items.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= items.valid;
            v2_reg <= n1_valid;
            v3_reg <= v2_reg;
            v4_reg <= n2_valid;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg[0]   <= DIFF_W'(items.target_x) - DIFF_W'(items.eye_x);
            d1_reg[1]   <= DIFF_W'(items.target_y) - DIFF_W'(items.eye_y);
            d1_reg[2]   <= DIFF_W'(items.target_z) - DIFF_W'(items.eye_z);
            eye1_reg[0] <= items.eye_x;
            eye1_reg[1] <= items.eye_y;
            eye1_reg[2] <= items.eye_z;
            up1_reg[0]  <= items.up_x;
            up1_reg[1]  <= items.up_y;
            up1_reg[2]  <= items.up_z;
        end
    end

    assign side1_in = {eye1_reg[0], eye1_reg[1], eye1_reg[2],
                       up1_reg[0], up1_reg[1], up1_reg[2]};

    lavm_norm #(
        .IN_W   (DIFF_W),
        .SIDE_W (SIDE1_W)
    ) u_norm_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v1_reg),
        .v         (d1_reg),
        .in_side   (side1_in),
        .out_valid (n1_valid),
        .unit_v    (f_n1),
        .zero      (zf_n1),
        .out_side  (side1_out)
    );

    assign eye_n1[0] = side1_out[191:160];
    assign eye_n1[1] = side1_out[159:128];
    assign eye_n1[2] = side1_out[127:96];
    assign up_n1[0]  = side1_out[95:64];
    assign up_n1[1]  = side1_out[63:32];
    assign up_n1[2]  = side1_out[31:0];

    // stages 2-3: right = f x up, unscaled q19.32
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa2_reg[0] <= f_n1[1] * up_n1[2];
            pb2_reg[0] <= f_n1[2] * up_n1[1];
            pa2_reg[1] <= f_n1[2] * up_n1[0];
            pb2_reg[1] <= f_n1[0] * up_n1[2];
            pa2_reg[2] <= f_n1[0] * up_n1[1];
            pb2_reg[2] <= f_n1[1] * up_n1[0];
            eye2_reg   <= eye_n1;
            f2_reg     <= f_n1;
            zf2_reg    <= zf_n1;
            for (int i = 0; i < 3; i++)
                sr3_reg[i] <= CROSS_W'(pa2_reg[i]) - CROSS_W'(pb2_reg[i]);
            eye3_reg   <= eye2_reg;
            f3_reg     <= f2_reg;
            zf3_reg    <= zf2_reg;
        end
    end

    assign side2_in = {eye3_reg[0], eye3_reg[1], eye3_reg[2],
                       f3_reg[0], f3_reg[1], f3_reg[2], zf3_reg};

    lavm_norm #(
        .IN_W   (CROSS_W),
        .SIDE_W (SIDE2_W)
    ) u_norm_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v3_reg),
        .v         (sr3_reg),
        .in_side   (side2_in),
        .out_valid (n2_valid),
        .unit_v    (s_n2),
        .zero      (zs_n2),
        .out_side  (side2_out)
    );

    assign eye_n2[0] = side2_out[150:119];
    assign eye_n2[1] = side2_out[118:87];
    assign eye_n2[2] = side2_out[86:55];
    assign f_n2[0]   = side2_out[54:37];
    assign f_n2[1]   = side2_out[36:19];
    assign f_n2[2]   = side2_out[18:1];

    // stage 4: s x f products and the s.eye, f.eye dot product terms
    // stage 5: differences and sums
    // stage 6: rounding, negation of the s.eye sum, and saturation
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            psa4_reg[0] <= s_n2[1] * f_n2[2];
            psb4_reg[0] <= s_n2[2] * f_n2[1];
            psa4_reg[1] <= s_n2[2] * f_n2[0];
            psb4_reg[1] <= s_n2[0] * f_n2[2];
            psa4_reg[2] <= s_n2[0] * f_n2[1];
            psb4_reg[2] <= s_n2[1] * f_n2[0];
            for (int i = 0; i < 3; i++)
            begin
                pse4_reg[i] <= s_n2[i] * eye_n2[i];
                pfe4_reg[i] <= f_n2[i] * eye_n2[i];
            end
            s4_reg   <= s_n2;
            f4_reg   <= f_n2;
            eye4_reg <= eye_n2;
            dg4_reg  <= side2_out[0] | zs_n2;

            for (int i = 0; i < 3; i++)
                ur5_reg[i] <= UR_W'(psa4_reg[i]) - UR_W'(psb4_reg[i]);
            ds5_reg  <= DOT_W'(pse4_reg[0]) + DOT_W'(pse4_reg[1]) + DOT_W'(pse4_reg[2]);
            df5_reg  <= DOT_W'(pfe4_reg[0]) + DOT_W'(pfe4_reg[1]) + DOT_W'(pfe4_reg[2]);
            s5_reg   <= s4_reg;
            f5_reg   <= f4_reg;
            eye5_reg <= eye4_reg;
            dg5_reg  <= dg4_reg;

            for (int i = 0; i < 3; i++)
                u6_reg[i] <= UP_W'(sat_sm(ur5_reg[i][UR_W-1], rnd_mag(64'(ur5_reg[i]))));
            t0_6_reg <= sat_sm(!ds5_reg[DOT_W-1], rnd_mag(64'(ds5_reg)));
            t2_6_reg <= sat_sm(df5_reg[DOT_W-1], rnd_mag(64'(df5_reg)));
            s6_reg   <= s5_reg;
            f6_reg   <= f5_reg;
            eye6_reg <= eye5_reg;
            dg6_reg  <= dg5_reg;
        end
    end

    // stage 7: u, eye products; stage 8: sum; stage 9: round, negate, saturate
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                pue7_reg[i] <= u6_reg[i] * eye6_reg[i];
            u7_reg   <= u6_reg;
            s7_reg   <= s6_reg;
            f7_reg   <= f6_reg;
            t0_7_reg <= t0_6_reg;
            t2_7_reg <= t2_6_reg;
            dg7_reg  <= dg6_reg;

            du8_reg  <= DOTU_W'(pue7_reg[0]) + DOTU_W'(pue7_reg[1]) + DOTU_W'(pue7_reg[2]);
            u8_reg   <= u7_reg;
            s8_reg   <= s7_reg;
            f8_reg   <= f7_reg;
            t0_8_reg <= t0_7_reg;
            t2_8_reg <= t2_7_reg;
            dg8_reg  <= dg7_reg;

            t1_9_reg <= sat_sm(!du8_reg[DOTU_W-1], rnd_mag(64'(du8_reg)));
            u9_reg   <= u8_reg;
            s9_reg   <= s8_reg;
            f9_reg   <= f8_reg;
            t0_9_reg <= t0_8_reg;
            t2_9_reg <= t2_8_reg;
            dg9_reg  <= dg8_reg;
        end
    end

    // output register and column counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            col_reg  <= '0;
        end
        else if (v9_reg && ser_take)
        begin
            full_reg <= 1'b1;
            col_reg  <= '0;
        end
        else if (full_reg && columns.ready)
        begin
            if (col_last)
                full_reg <= 1'b0;
            col_reg <= col_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v9_reg && ser_take)
        begin
            so_reg    <= s9_reg;
            uo_reg    <= u9_reg;
            fo_reg    <= f9_reg;
            to_reg[0] <= t0_9_reg;
            to_reg[1] <= t1_9_reg;
            to_reg[2] <= t2_9_reg;
            dgo_reg   <= dg9_reg;
        end
    end

    // columns 0..2 are (s, u, -f, 0); column 3 is the translation and one
    always_comb
    begin
        columns.valid        = full_reg;
        columns.column_index = col_reg;
        columns.degenerate   = dgo_reg;
        columns.last_column  = col_last;
        if (col_last)
        begin
            columns.row0_value = to_reg[0];
            columns.row1_value = to_reg[1];
            columns.row2_value = to_reg[2];
            columns.row3_value = Q_ONE;
        end
        else
        begin
            columns.row0_value = COORD_W'(so_reg[col_reg]);
            columns.row1_value = COORD_W'(uo_reg[col_reg]);
            columns.row2_value = -COORD_W'(fo_reg[col_reg]);
            columns.row3_value = '0;
        end
    end

endmodule
